@@ design/hht_pkg.sv @@
// ----------------------------------------------------------------------------
// Handle translation table package
// Shared constants, field widths and operation codes for the translation table.
// ----------------------------------------------------------------------------
package hht_pkg;

  // Default number of table entries.
  localparam int unsigned TableDepthDef = 64;

  // Field widths.
  localparam int unsigned HostW   = 64;
  localparam int unsigned GuestW  = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SweepW  = 17;

  // One stored entry is {valid, guest handle, host handle}.
  localparam int unsigned EntryW = 1 + GuestW + HostW;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 104;

  // Configuration port.
  localparam int unsigned PAddrW = 2;
  localparam int unsigned PDataW = 32;
  localparam logic [PAddrW-1:0] AddrSweep = '0;

  // Reset value of the sweep interval register.
  localparam logic [SweepW-1:0] SweepReset = 17'h1_0000;

  typedef enum logic [OpW-1:0] {
    OP_ADD        = 3'd0,
    OP_ADD_OR_GET = 3'd1,
    OP_GUEST2HOST = 3'd2,
    OP_HOST2GUEST = 3'd3,
    OP_REMOVE     = 3'd4
  } op_e;

  localparam logic [StatusW-1:0] StatOk   = 2'd0;
  localparam logic [StatusW-1:0] StatMiss = 2'd1;
  localparam logic [StatusW-1:0] StatFull = 2'd2;

endpackage

@@ design/hht_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the contents.
// ----------------------------------------------------------------------------
module hht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/handle_translation_table.sv @@
// ----------------------------------------------------------------------------
// Handle translation table
// Maps 64-bit host handles to 32-bit guest handles in both directions, with
// a guest handle counter that is rebuilt from the table every so many removals.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                          Content
//  --------  ---------  -------------------------------  ----------------------
//  s_axis    in         tvalid, tready, tdata[103:0]     one request per transfer
//  m_axis    out        tvalid, tready, tdata[103:0]     one response per request
//  apb       in/out     psel, penable, pwrite, paddr,    sweep interval register
//                       pwdata, prdata, pready           at byte address 0
//
// Each request runs a scan and then a decision before its response is offered:
// the whole table is read once through the single read port of the entry RAM,
// one entry a cycle, the last entry is compared in the cycle after its read,
// and a decision state writes the entry, if the operation changes it, and
// loads the output register. The next request is taken only once the block is
// back in idle, so requests do not overlap. s_axis_tready is high only while
// the block idles. After reset a clearing pass marks every entry invalid; no
// request is taken during it, though register writes are. A response that is
// not taken holds the next request in its decision state until it leaves.
// ----------------------------------------------------------------------------
module handle_translation_table #(
  parameter int unsigned TABLE_DEPTH = hht_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] op, [66:3] host_handle, [98:67] guest_handle, rest zero.
  input  logic [hht_pkg::InDataW-1:0]   s_axis_tdata,
  // Response stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] guest_result, [95:32] host_result, [97:96] status, rest zero.
  output logic [hht_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hht_pkg::PAddrW-1:0]    paddr,
  input  logic [hht_pkg::PDataW-1:0]    pwdata,
  output logic [hht_pkg::PDataW-1:0]    prdata,
  output logic                          pready
);

  import hht_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  // Control state.
  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic                hit_q, hit_d;
  logic                free_q, free_d;
  logic [GuestW-1:0]   next_guest_q, next_guest_d;
  logic [SweepW-1:0]   rem_cnt_q, rem_cnt_d;
  logic [SweepW-1:0]   sweep_q;
  logic                out_vld_q, out_vld_d;

  // Payload state.
  op_e                 op_q;
  logic [HostW-1:0]    key_host_q;
  logic [GuestW-1:0]   key_guest_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic [IdxW-1:0]     hit_idx_q;
  logic [GuestW-1:0]   hit_guest_q;
  logic [HostW-1:0]    hit_host_q;
  logic [IdxW-1:0]     free_idx_q;
  logic [GuestW-1:0]   max_q, max_d;
  logic [GuestW-1:0]   out_guest_q;
  logic [HostW-1:0]    out_host_q;
  logic [StatusW-1:0]  out_status_q;

  // Entry RAM ports.
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [EntryW-1:0]   ram_wdata;
  logic                ram_re;
  logic [EntryW-1:0]   ram_rdata;

  // Read entry fields.
  logic                ent_valid;
  logic [GuestW-1:0]   ent_guest;
  logic [HostW-1:0]    ent_host;
  logic                ent_match;
  logic                ent_first;

  // Decision results.
  logic                in_xfer;
  logic                fire;
  logic                dec_we;
  logic [IdxW-1:0]     dec_idx;
  logic [EntryW-1:0]   dec_entry;
  logic [GuestW-1:0]   res_guest;
  logic [HostW-1:0]    res_host;
  logic [StatusW-1:0]  res_status;
  logic [GuestW-1:0]   dec_next_guest;
  logic [SweepW-1:0]   dec_rem_cnt;
  logic [SweepW-1:0]   rem_inc;
  logic                do_add;
  logic                cfg_we;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign fire    = (state_q == S_DECIDE) && (!out_vld_q || m_axis_tready);

  // --------------------------------------------------------------------------
  // Entry memory: {valid, guest, host} per entry.
  // --------------------------------------------------------------------------
  hht_ram #(
    .Width (EntryW),
    .Depth (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // During the clearing pass every entry is written with its valid bit low.
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[IdxW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = fire && dec_we;
      ram_waddr = dec_idx;
      ram_wdata = dec_entry;
    end
  end

  assign ram_re = (state_q == S_SCAN) && (cnt_q < CntW'(TABLE_DEPTH));

  // --------------------------------------------------------------------------
  // Scan unit: one entry a cycle is compared against the key. It records the
  // first match, the first free slot, and the largest guest handle among the
  // valid entries other than the first match (the one a removal takes out).
  // --------------------------------------------------------------------------
  assign ent_valid = ram_rdata[EntryW-1];
  assign ent_guest = ram_rdata[HostW +: GuestW];
  assign ent_host  = ram_rdata[HostW-1:0];

  assign ent_match = ent_valid && ((op_q == OP_GUEST2HOST) ? (ent_guest == key_guest_q)
                                                           : (ent_host == key_host_q));
  assign ent_first = rd_vld_q && ent_match && !hit_q;

  always_comb begin
    max_d = max_q;
    if (rd_vld_q && ent_valid && !ent_first && (ent_guest > max_q)) begin
      max_d = ent_guest;
    end
  end

  // --------------------------------------------------------------------------
  // Decision: what the finished scan means for the requested operation.
  // --------------------------------------------------------------------------
  assign rem_inc = rem_cnt_q + SweepW'(1);

  always_comb begin
    dec_we         = 1'b0;
    dec_idx        = hit_idx_q;
    dec_entry      = {1'b1, next_guest_q, key_host_q};
    res_guest      = '0;
    res_host       = '0;
    res_status     = StatMiss;
    dec_next_guest = next_guest_q;
    dec_rem_cnt    = rem_cnt_q;
    do_add         = 1'b0;

    case (op_q)
      OP_ADD: begin
        do_add = 1'b1;
      end
      OP_ADD_OR_GET: begin
        if (hit_q) begin
          res_guest  = hit_guest_q;
          res_status = StatOk;
        end else begin
          do_add = 1'b1;
        end
      end
      OP_GUEST2HOST: begin
        if (hit_q) begin
          res_host   = hit_host_q;
          res_status = StatOk;
        end
      end
      OP_HOST2GUEST: begin
        if (hit_q) begin
          res_guest  = hit_guest_q;
          res_status = StatOk;
        end
      end
      OP_REMOVE: begin
        if (hit_q) begin
          dec_we     = 1'b1;
          dec_entry  = {1'b0, hit_guest_q, key_host_q};
          res_guest  = hit_guest_q;
          res_status = StatOk;
          // Every sweep_interval-th removal rebuilds the counter from the table.
          if (rem_inc == sweep_q) begin
            dec_next_guest = max_q + GuestW'(1);
            dec_rem_cnt    = '0;
          end else begin
            dec_rem_cnt = rem_inc;
          end
        end
      end
      default: begin
      end
    endcase

    // An add rebinds a present host handle, else takes the lowest free slot.
    if (do_add) begin
      if (hit_q || free_q) begin
        dec_we         = 1'b1;
        dec_idx        = hit_q ? hit_idx_q : free_idx_q;
        res_guest      = next_guest_q;
        res_status     = StatOk;
        dec_next_guest = next_guest_q + GuestW'(1);
      end else begin
        res_status = StatFull;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    hit_d        = hit_q || ent_first;
    free_d       = free_q || (rd_vld_q && !ent_valid);
    next_guest_d = next_guest_q;
    rem_cnt_d    = rem_cnt_q;
    out_vld_d    = out_vld_q && !m_axis_tready;

    case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (cnt_q < CntW'(TABLE_DEPTH)) begin
          cnt_d    = cnt_q + CntW'(1);
          rd_vld_d = 1'b1;
        end else begin
          // The last entry is being looked at in this cycle.
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (fire) begin
          state_d      = S_IDLE;
          next_guest_d = dec_next_guest;
          rem_cnt_d    = dec_rem_cnt;
          out_vld_d    = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      next_guest_q <= '0;
      rem_cnt_q    <= '0;
      sweep_q      <= SweepReset;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rd_vld_q     <= rd_vld_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
      next_guest_q <= next_guest_d;
      rem_cnt_q    <= rem_cnt_d;
      out_vld_q    <= out_vld_d;
      if (cfg_we) begin
        sweep_q <= pwdata[SweepW-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q        <= op_e'(s_axis_tdata[OpW-1:0]);
      key_host_q  <= s_axis_tdata[OpW +: HostW];
      key_guest_q <= s_axis_tdata[OpW + HostW +: GuestW];
      max_q       <= '0;
    end else begin
      max_q <= max_d;
    end
    rd_idx_q <= cnt_q[IdxW-1:0];
    if (ent_first) begin
      hit_idx_q   <= rd_idx_q;
      hit_guest_q <= ent_guest;
      hit_host_q  <= ent_host;
    end
    if (rd_vld_q && !ent_valid && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (fire) begin
      out_guest_q  <= res_guest;
      out_host_q   <= res_host;
      out_status_q <= res_status;
    end
  end

  // --------------------------------------------------------------------------
  // Ports.
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - GuestW - HostW - StatusW)'(0),
                          out_status_q, out_host_q, out_guest_q};

  assign cfg_we = psel && penable && pwrite && (paddr == AddrSweep);
  assign pready = 1'b1;
  assign prdata = (paddr == AddrSweep) ? {(PDataW - SweepW)'(0), sweep_q} : '0;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A request holds the input side closed while its scan runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("request taken while a scan is under way");

  // The status field never carries an unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_status_q == StatOk || out_status_q == StatMiss ||
                       out_status_q == StatFull))
    else $error("undefined status code in response");

  // A miss or a full table returns zero handles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status_q != StatOk) |-> (out_guest_q == '0 && out_host_q == '0))
    else $error("non-zero handle on a failed request");

  // The entry memory is written only during the clearing pass or a decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_DECIDE))
    else $error("entry memory written outside clear or decision");

endmodule

@@ verif/hht_checker.sv @@
// ----------------------------------------------------------------------------
// Handle translation table checker
// Follows every request transfer and works out the response that the table
// owes for it. Each response transfer is then compared with the oldest one
// still owed. Register writes and reads on the configuration port are also
// followed.
// ----------------------------------------------------------------------------
module hht_checker #(
  parameter int unsigned TABLE_DEPTH = hht_pkg::TableDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  // [2:0] op, [66:3] host_handle, [98:67] guest_handle, rest zero.
  input  logic [hht_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  // [31:0] guest_result, [95:32] host_result, [97:96] status, rest zero.
  input  logic [hht_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [hht_pkg::PAddrW-1:0]   paddr_i,
  input  logic [hht_pkg::PDataW-1:0]   pwdata_i,
  input  logic [hht_pkg::PDataW-1:0]   prdata_i,
  input  logic                         pready_i,
  output int unsigned                  err_cnt_o,
  output int unsigned                  owed_cnt_o
);
  import hht_pkg::*;

  typedef struct packed {
    logic [GuestW-1:0]  guest;
    logic [HostW-1:0]   host;
    logic [StatusW-1:0] status;
  } resp_t;

  logic               tbl_valid [TABLE_DEPTH];
  logic [HostW-1:0]   tbl_host  [TABLE_DEPTH];
  logic [GuestW-1:0]  tbl_guest [TABLE_DEPTH];
  logic [GuestW-1:0]  next_guest;
  logic [SweepW-1:0]  removal_cnt;
  logic [SweepW-1:0]  sweep_q;
  resp_t              owed_q [$];
  int unsigned        err_cnt;

  function automatic int host_slot(logic [HostW-1:0] h);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_host[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic int guest_slot(logic [GuestW-1:0] g);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_guest[i] == g) return i;
    end
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tbl_valid[i]) return i;
    end
    return -1;
  endfunction

  // A present host is rebound in place; otherwise the lowest free slot is taken.
  function automatic logic [StatusW-1:0] bind_host(logic [HostW-1:0] h,
                                                   output logic [GuestW-1:0] g);
    int slot;
    g    = '0;
    slot = host_slot(h);
    if (slot < 0) slot = free_slot();
    if (slot < 0) return StatFull;
    tbl_valid[slot] = 1'b1;
    tbl_host[slot]  = h;
    tbl_guest[slot] = next_guest;
    g               = next_guest;
    next_guest      = next_guest + 1'b1;
    return StatOk;
  endfunction

  function automatic void rebuild_counter();
    logic [GuestW-1:0] top_guest;
    top_guest = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_guest[i] > top_guest) top_guest = tbl_guest[i];
    end
    next_guest = top_guest + 1'b1;
  endfunction

  function automatic resp_t translate(logic [OpW-1:0] op, logic [HostW-1:0] h,
                                      logic [GuestW-1:0] g);
    resp_t r;
    int    slot;
    r = '{guest: '0, host: '0, status: StatMiss};
    case (op)
      OP_ADD: begin
        r.status = bind_host(h, r.guest);
      end
      OP_ADD_OR_GET: begin
        slot = host_slot(h);
        if (slot >= 0) begin
          r.guest  = tbl_guest[slot];
          r.status = StatOk;
        end else begin
          r.status = bind_host(h, r.guest);
        end
      end
      OP_GUEST2HOST: begin
        slot = guest_slot(g);
        if (slot >= 0) begin
          r.host   = tbl_host[slot];
          r.status = StatOk;
        end
      end
      OP_HOST2GUEST: begin
        slot = host_slot(h);
        if (slot >= 0) begin
          r.guest  = tbl_guest[slot];
          r.status = StatOk;
        end
      end
      OP_REMOVE: begin
        slot = host_slot(h);
        if (slot >= 0) begin
          r.guest         = tbl_guest[slot];
          r.status        = StatOk;
          tbl_valid[slot] = 1'b0;
          removal_cnt     = removal_cnt + 1'b1;
          if (removal_cnt == sweep_q) begin
            rebuild_counter();
            removal_cnt = '0;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t got;
    resp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
      next_guest  = '0;
      removal_cnt = '0;
      sweep_q     = SweepReset;
      err_cnt     = 0;
      owed_q.delete();
      err_cnt_o  <= 0;
      owed_cnt_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.guest  = m_tdata_i[31:0];
        got.host   = m_tdata_i[95:32];
        got.status = m_tdata_i[97:96];
        if (owed_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: response with none owed: guest %h host %h status %0d",
                     $realtime, got.guest, got.host, got.status);
        end else begin
          want = owed_q.pop_front();
          if (got.guest !== want.guest || got.host !== want.host ||
              got.status !== want.status) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: response mismatch: expected guest %h host %h status %0d, got guest %h host %h status %0d",
                       $realtime, want.guest, want.host, want.status,
                       got.guest, got.host, got.status);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        owed_q.push_back(translate(s_tdata_i[2:0], s_tdata_i[66:3], s_tdata_i[98:67]));
      if (psel_i && penable_i && pready_i && paddr_i == AddrSweep) begin
        if (pwrite_i) begin
          sweep_q = pwdata_i[SweepW-1:0];
        end else if (prdata_i !== PDataW'(sweep_q)) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: sweep interval read mismatch: expected %h, got %h",
                     $realtime, PDataW'(sweep_q), prdata_i);
        end
      end
      err_cnt_o  <= err_cnt;
      owed_cnt_o <= owed_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Handle translation table testbench
// Drives requests and register accesses into the table, with a separate
// checker that predicts each response. A short directed opening is followed
// by several phases of random requests under different idling patterns and
// sweep intervals.
// ----------------------------------------------------------------------------
module tb_top;
  import hht_pkg::*;

  localparam int unsigned Depth       = TableDepthDef;
  // Cycles from a request transfer to its response, with some margin.
  localparam int unsigned Latency     = Depth + 8;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PoolSize    = 96;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 170;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PAddrW-1:0]    paddr         = '0;
  logic [PDataW-1:0]    pwdata        = '0;
  logic [PDataW-1:0]    prdata;
  logic                 pready;

  int unsigned          err_cnt;
  int unsigned          owed_cnt;
  int unsigned          cycle_cnt     = 0;

  // Idling pattern of the current phase, in percent per cycle.
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;

  // A long hold-off is requested by bumping hold_req; the receiver process
  // notices the change and counts the hold-off down itself.
  int unsigned          hold_req      = 0;
  int unsigned          hold_seen     = 0;
  int unsigned          hold_left     = 0;

  // Host handles that the random requests mostly pick from, so that adds,
  // lookups and removals hit one another and the table fills up.
  logic [HostW-1:0]     host_pool [PoolSize];
  int unsigned          adds_sent     = 0;

  handle_translation_table #(
    .TABLE_DEPTH (Depth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  hht_checker #(
    .TABLE_DEPTH (Depth)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_i   (prdata),
    .pready_i   (pready),
    .err_cnt_o  (err_cnt),
    .owed_cnt_o (owed_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a run that hangs, or leaves a response owed, ends here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Response side. The ready line changes only at the falling edge. During a
  // requested hold-off it stays low, so the response register stays full and
  // the block stops taking requests while the sender keeps offering them.
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one request, starting at a falling edge, and returns at the falling
  // edge after its transfer. Random idle cycles come first, as the phase asks;
  // when there are none, valid simply stays high from the previous request.
  task automatic send_req(input logic [OpW-1:0] op, input logic [HostW-1:0] h,
                          input logic [GuestW-1:0] g);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, g, h, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register access through the setup and access cycles of the port.
  task automatic reg_access(input logic wr, input logic [PDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrSweep;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets the block drain, then sets up the next phase: the idling pattern,
  // an optional long hold-off and a new sweep interval, which is read back.
  task automatic start_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input logic [PDataW-1:0] sweep, input logic hold);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_cnt != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_req++;
    @(negedge clk_i);
    reg_access(1'b1, sweep);
    reg_access(1'b0, '0);
  endtask

  // One random request. Most are well formed, on handles from the pool and on
  // guest handles near those handed out so far; the rest are pure noise,
  // unknown operations among them.
  task automatic send_random(input int unsigned rem_pct, input int unsigned add_pct);
    int unsigned       pick;
    logic [OpW-1:0]    op;
    logic [HostW-1:0]  h;
    logic [GuestW-1:0] g;
    if ($urandom_range(99) < 12) begin
      op = OpW'($urandom_range(7));
      h  = {$urandom, $urandom};
      g  = $urandom;
    end else begin
      pick = $urandom_range(99);
      if (pick < add_pct / 2) op = OP_ADD;
      else if (pick < add_pct) op = OP_ADD_OR_GET;
      else if (pick < add_pct + rem_pct) op = OP_REMOVE;
      else if (pick[0]) op = OP_GUEST2HOST;
      else op = OP_HOST2GUEST;
      h = host_pool[$urandom_range(PoolSize - 1)];
      g = $urandom_range(adds_sent + 1);
    end
    if (op == OP_ADD || op == OP_ADD_OR_GET) adds_sent++;
    send_req(op, h, g);
  endtask

  initial begin
    int unsigned       idle_tab  [NumPhases];
    int unsigned       stall_tab [NumPhases];
    int unsigned       sweep_tab [NumPhases];
    int unsigned       rem_tab   [NumPhases];
    int unsigned       add_tab   [NumPhases];
    logic [HostW-1:0]  rand_host;

    // Phases cycle through the idling patterns: none, sender idle, receiver
    // stalling, both. Sweep intervals run from 1 to 65536, and the remove and
    // add mixes alternately fill the table to full and drain it to empty.
    idle_tab  = '{0,  67, 0,  11, 0,  11, 67};
    stall_tab = '{0,  0,  67, 11, 0,  11, 67};
    sweep_tab = '{65536, 1, 2, 5, 1, 3, 65536};
    rem_tab   = '{10, 40, 30, 25, 70, 15, 35};
    add_tab   = '{60, 35, 40, 45, 10, 60, 40};

    host_pool[0] = '0;
    host_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) host_pool[i] = {$urandom, $urandom};
    rand_host = {$urandom, $urandom};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The register may be written during the clearing pass after reset.
    reg_access(1'b1, 32'd65536);
    reg_access(1'b0, '0);

    // Directed opening: misses on an empty table, adds at the handle
    // extremes, add-or-get of a present and of a new handle, rebinding of a
    // present host, lookups both ways, unknown operations and removal.
    send_req(OP_REMOVE,     '0, '0);
    send_req(OP_GUEST2HOST, '0, '0);
    send_req(OP_HOST2GUEST, '1, '1);
    send_req(OP_ADD,        '0, '1);
    send_req(OP_ADD,        '1, '0);
    send_req(OP_ADD_OR_GET, '0, '0);
    send_req(OP_ADD_OR_GET, rand_host, '0);
    send_req(OP_ADD,        '0, '0);
    send_req(OP_GUEST2HOST, '1, 32'd3);
    send_req(OP_GUEST2HOST, '0, 32'd0);
    send_req(OP_GUEST2HOST, '0, '1);
    send_req(OP_HOST2GUEST, '1, '0);
    send_req(OP_HOST2GUEST, rand_host, '0);
    send_req(3'd5, {$urandom, $urandom}, $urandom);
    send_req(3'd6, '1, '1);
    send_req(3'd7, '0, '0);
    send_req(OP_REMOVE,     '1, '0);
    send_req(OP_REMOVE,     '1, '0);
    send_req(OP_HOST2GUEST, '1, '0);
    send_req(OP_REMOVE,     rand_host, '0);
    send_req(OP_ADD_OR_GET, '1, '1);
    adds_sent = 6;

    for (int p = 0; p < NumPhases; p++) begin
      // The long hold-off falls in the receiver-stalling phase.
      start_phase(idle_tab[p], stall_tab[p], sweep_tab[p], p == 2);
      for (int n = 0; n < PhaseItems; n++) send_random(rem_tab[p], add_tab[p]);
    end

    // Every response must arrive; the watchdog covers one that never does.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_cnt != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
